FILE: design/scrb_pkg.sv
`timescale 1ns / 1ps

package scrb_pkg;

   // device count of the reset-enable register and the one device that
   // fires on a rising bit
   localparam int RESET_DEVICES = 17;
   localparam int SC_DEVICE     = 1;

   localparam int DATA_W = 32;
   localparam int OFF_W  = 12;

   // configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_DATA_W-1:0] FUSE_ID_RESET     = 64'h0000_590B_B2A1_8793;
   localparam logic [DATA_W-1:0]     FUSE_CONFIG_RESET = 32'h0000_590B;

   localparam logic [DATA_W-1:0] RAM_KEEP_MASK  = 32'hFF00_0800;
   localparam logic [DATA_W-1:0] RAM_WRITE_MASK = 32'h00FF_F7FF;
   localparam logic [DATA_W-1:0] RAM_RESET_WORD = 32'h4000_0001;
   localparam logic [DATA_W-1:0] CARD_BIT       = 32'h0000_0100;

   typedef enum logic [1:0] {
      OP_READ        = 2'd0,
      OP_WRITE       = 2'd1,
      OP_CARD_INSERT = 2'd2,
      OP_CARD_REMOVE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TOLERATED = 2'd1,
      ST_ERROR     = 2'd2
   } status_type;

   // configuration register indexes
   localparam logic CFG_FUSE_ID     = 1'b0;
   localparam logic CFG_FUSE_CONFIG = 1'b1;

   // register offsets
   localparam logic [OFF_W-1:0] OFF_NMI_ENABLE   = 12'h000;
   localparam logic [OFF_W-1:0] OFF_NMI_FLAG     = 12'h004;
   localparam logic [OFF_W-1:0] OFF_TOLERATED_A  = 12'h03C;
   localparam logic [OFF_W-1:0] OFF_RAM_SIZE     = 12'h040;
   localparam logic [OFF_W-1:0] OFF_POSTME       = 12'h044;
   localparam logic [OFF_W-1:0] OFF_RESET_ENABLE = 12'h04C;
   localparam logic [OFF_W-1:0] OFF_BUS_CLK_EN   = 12'h050;
   localparam logic [OFF_W-1:0] OFF_CLK_EN_LO    = 12'h054;
   localparam logic [OFF_W-1:0] OFF_CLK_EN_HI    = 12'h058;
   localparam logic [OFF_W-1:0] OFF_CLK_SEL_LO   = 12'h05C;
   localparam logic [OFF_W-1:0] OFF_CLK_SEL_HI   = 12'h060;
   localparam logic [OFF_W-1:0] OFF_SPI_CLK_SEL  = 12'h064;
   localparam logic [OFF_W-1:0] OFF_PLL_CONTROL  = 12'h068;
   localparam logic [OFF_W-1:0] OFF_AV_POWER     = 12'h070;
   localparam logic [OFF_W-1:0] OFF_TOLERATED_B  = 12'h074;
   localparam logic [OFF_W-1:0] OFF_IO_ENABLE    = 12'h078;
   localparam logic [OFF_W-1:0] OFF_GPIO_ENABLE  = 12'h07C;
   localparam logic [OFF_W-1:0] OFF_CONNECTION   = 12'h080;
   localparam logic [OFF_W-1:0] OFF_FUSE_ID_LO   = 12'h090;
   localparam logic [OFF_W-1:0] OFF_FUSE_ID_HI   = 12'h094;
   localparam logic [OFF_W-1:0] OFF_FUSE_CONFIG  = 12'h098;
   localparam logic [OFF_W-1:0] OFF_PLL_MULT     = 12'h0FC;

endpackage

FILE: design/system_control_register_block_unit.sv
`timescale 1ns / 1ps

// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+-----------------------------------------
// request   | in        | req_valid/req_stall  | req_op, req_address_offset, req_write_data
// response  | out       | rsp_valid/rsp_stall  | rsp_read_data, rsp_access_status,
//           |           |                      | rsp_me_interrupt, rsp_reset_pulse,
//           |           |                      | rsp_gpio_enable_out
// csr       | in/out    | APB, pready always 1 | paddr, pwdata, prdata (fuse id, fuse config)
//
// One request per cycle sustained while the response is not stalled; each request passes
// the request register, then the decode and register update into the response register.
// Reset is synchronous, active high: the register file and csr registers take their reset
// words and both stages empty.
// A stalled response holds the response register; the request register keeps taking a
// request as long as it can hand its own one on, so req_stall rises only when both
// stages are full and the response is stalled.
module system_control_register_block_unit
   import scrb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_op,
   input  logic [OFF_W-1:0]      req_address_offset,
   input  logic [DATA_W-1:0]     req_write_data,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DATA_W-1:0]     rsp_read_data,
   output logic [1:0]            rsp_access_status,
   output logic                  rsp_me_interrupt,
   output logic [RESET_DEVICES-1:0] rsp_reset_pulse,
   output logic [DATA_W-1:0]     rsp_gpio_enable_out,

   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // ---------------------------------------------------------------- csr port
   logic [CSR_DATA_W-1:0] fuse_id_ff;
   logic [DATA_W-1:0]     fuse_config_ff;
   logic                  csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   // registers sit at 8-byte steps, so bit 3 picks the register
   assign prdata = (paddr[3] == CFG_FUSE_ID) ? fuse_id_ff
                                             : {{(CSR_DATA_W-DATA_W){1'b0}}, fuse_config_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         fuse_id_ff     <= FUSE_ID_RESET;
         fuse_config_ff <= FUSE_CONFIG_RESET;
      end else if (csr_write) begin
         if (paddr[3] == CFG_FUSE_ID) begin
            fuse_id_ff <= pwdata;
         end else begin
            fuse_config_ff <= pwdata[DATA_W-1:0];
         end
      end
   end

   // ---------------------------------------------------------------- flow control
   logic              in_valid_ff;
   op_type            in_op_ff;
   logic [OFF_W-1:0]  in_off_ff;
   logic [DATA_W-1:0] in_data_ff;
   logic              out_valid_ff;
   logic              advance;

   // stage 1 hands its request on when the response register is free or emptying
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_op_ff   <= op_type'(req_op);
         in_off_ff  <= req_address_offset;
         in_data_ff <= req_write_data;
      end
   end

   // ---------------------------------------------------------------- register file
   logic [DATA_W-1:0] ram_size_ff,    ram_size_in;
   logic [DATA_W-1:0] reset_en_ff,    reset_en_in;
   logic [DATA_W-1:0] bus_clk_en_ff,  bus_clk_en_in;
   logic [DATA_W-1:0] clk_en_lo_ff,   clk_en_lo_in;
   logic [DATA_W-1:0] clk_en_hi_ff,   clk_en_hi_in;
   logic [DATA_W-1:0] clk_sel_lo_ff,  clk_sel_lo_in;
   logic [DATA_W-1:0] clk_sel_hi_ff,  clk_sel_hi_in;
   logic [DATA_W-1:0] spi_clk_sel_ff, spi_clk_sel_in;
   logic [DATA_W-1:0] pll_ctrl_ff,    pll_ctrl_in;
   logic [DATA_W-1:0] av_power_ff,    av_power_in;
   logic [DATA_W-1:0] io_en_ff,       io_en_in;
   logic [DATA_W-1:0] gpio_en_ff,     gpio_en_in;
   logic [DATA_W-1:0] conn_ff,        conn_in;

   // result of the request in stage 1
   logic [DATA_W-1:0] rd_data;
   status_type        status;
   logic              irq;
   logic [DATA_W-1:0] pulses;
   logic [DATA_W-1:0] dev_mask;
   logic [DATA_W-1:0] rise_mask;

   // devices present, and the one device that pulses on a rising bit
   assign dev_mask  = (RESET_DEVICES >= DATA_W) ? {DATA_W{1'b1}}
                    : DATA_W'((64'd1 << RESET_DEVICES) - 64'd1);
   assign rise_mask = DATA_W'(64'd1 << SC_DEVICE);

   always_comb begin
      ram_size_in    = ram_size_ff;
      reset_en_in    = reset_en_ff;
      bus_clk_en_in  = bus_clk_en_ff;
      clk_en_lo_in   = clk_en_lo_ff;
      clk_en_hi_in   = clk_en_hi_ff;
      clk_sel_lo_in  = clk_sel_lo_ff;
      clk_sel_hi_in  = clk_sel_hi_ff;
      spi_clk_sel_in = spi_clk_sel_ff;
      pll_ctrl_in    = pll_ctrl_ff;
      av_power_in    = av_power_ff;
      io_en_in       = io_en_ff;
      gpio_en_in     = gpio_en_ff;
      conn_in        = conn_ff;
      rd_data        = '0;
      status         = ST_OK;
      irq            = 1'b0;
      pulses         = '0;

      unique case (in_op_ff)
         OP_READ: begin
            unique case (in_off_ff)
               OFF_NMI_ENABLE:   rd_data = '0;
               OFF_RAM_SIZE:     rd_data = ram_size_ff;
               OFF_RESET_ENABLE: rd_data = reset_en_ff;
               OFF_BUS_CLK_EN:   rd_data = bus_clk_en_ff;
               OFF_CLK_EN_LO:    rd_data = clk_en_lo_ff;
               OFF_CLK_EN_HI:    rd_data = clk_en_hi_ff;
               OFF_CLK_SEL_LO:   rd_data = clk_sel_lo_ff;
               OFF_CLK_SEL_HI:   rd_data = clk_sel_hi_ff;
               OFF_SPI_CLK_SEL:  rd_data = spi_clk_sel_ff;
               OFF_PLL_CONTROL:  rd_data = pll_ctrl_ff;
               OFF_AV_POWER:     rd_data = av_power_ff;
               OFF_IO_ENABLE:    rd_data = io_en_ff;
               OFF_GPIO_ENABLE:  rd_data = gpio_en_ff;
               OFF_CONNECTION:   rd_data = conn_ff;
               OFF_FUSE_ID_LO:   rd_data = fuse_id_ff[DATA_W-1:0];
               OFF_FUSE_ID_HI:   rd_data = fuse_id_ff[CSR_DATA_W-1:DATA_W];
               OFF_FUSE_CONFIG:  rd_data = fuse_config_ff;
               OFF_PLL_MULT:     rd_data = '0;
               OFF_TOLERATED_A,
               OFF_TOLERATED_B:  status  = ST_TOLERATED;
               default:          status  = ST_ERROR;
            endcase
         end
         OP_WRITE: begin
            unique case (in_off_ff)
               OFF_NMI_FLAG:     status = ST_OK;
               // version bits stay as they are
               OFF_RAM_SIZE:     ram_size_in = (ram_size_ff & RAM_KEEP_MASK)
                                             | (in_data_ff & RAM_WRITE_MASK);
               OFF_POSTME:       irq = in_data_ff[0];
               OFF_RESET_ENABLE: begin
                  reset_en_in = in_data_ff;
                  pulses = dev_mask & ((rise_mask & ~reset_en_ff & in_data_ff)
                                     | (~rise_mask & reset_en_ff & ~in_data_ff));
               end
               OFF_BUS_CLK_EN:   bus_clk_en_in  = in_data_ff;
               OFF_CLK_EN_LO:    clk_en_lo_in   = in_data_ff;
               OFF_CLK_EN_HI:    clk_en_hi_in   = in_data_ff;
               OFF_CLK_SEL_LO:   clk_sel_lo_in  = in_data_ff;
               OFF_CLK_SEL_HI:   clk_sel_hi_in  = in_data_ff;
               OFF_SPI_CLK_SEL:  spi_clk_sel_in = in_data_ff;
               OFF_PLL_CONTROL:  pll_ctrl_in    = in_data_ff;
               OFF_AV_POWER:     av_power_in    = in_data_ff;
               OFF_IO_ENABLE:    io_en_in       = in_data_ff;
               OFF_GPIO_ENABLE:  gpio_en_in     = in_data_ff;
               OFF_CONNECTION:   status = ST_OK;   // status is read-only
               OFF_TOLERATED_A,
               OFF_TOLERATED_B:  status = ST_TOLERATED;
               default:          status = ST_ERROR;
            endcase
         end
         OP_CARD_INSERT: conn_in = conn_ff | CARD_BIT;
         OP_CARD_REMOVE: conn_in = conn_ff & ~CARD_BIT;
         default:        status  = ST_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_size_ff    <= RAM_RESET_WORD;
         reset_en_ff    <= '0;
         bus_clk_en_ff  <= '0;
         clk_en_lo_ff   <= '0;
         clk_en_hi_ff   <= '0;
         clk_sel_lo_ff  <= '0;
         clk_sel_hi_ff  <= '0;
         spi_clk_sel_ff <= '0;
         pll_ctrl_ff    <= '0;
         av_power_ff    <= '0;
         io_en_ff       <= '0;
         gpio_en_ff     <= '0;
         conn_ff        <= '0;
      end else if (advance) begin
         ram_size_ff    <= ram_size_in;
         reset_en_ff    <= reset_en_in;
         bus_clk_en_ff  <= bus_clk_en_in;
         clk_en_lo_ff   <= clk_en_lo_in;
         clk_en_hi_ff   <= clk_en_hi_in;
         clk_sel_lo_ff  <= clk_sel_lo_in;
         clk_sel_hi_ff  <= clk_sel_hi_in;
         spi_clk_sel_ff <= spi_clk_sel_in;
         pll_ctrl_ff    <= pll_ctrl_in;
         av_power_ff    <= av_power_in;
         io_en_ff       <= io_en_in;
         gpio_en_ff     <= gpio_en_in;
         conn_ff        <= conn_in;
      end
   end

   // ---------------------------------------------------------------- response register
   logic [DATA_W-1:0]        rsp_read_data_ff;
   logic [1:0]               rsp_status_ff;
   logic                     rsp_irq_ff;
   logic [RESET_DEVICES-1:0] rsp_pulse_ff;
   logic [DATA_W-1:0]        rsp_gpio_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_read_data_ff <= rd_data;
         rsp_status_ff    <= status;
         rsp_irq_ff       <= irq;
         rsp_pulse_ff     <= pulses[RESET_DEVICES-1:0];
         rsp_gpio_ff      <= gpio_en_in;
      end
   end

   assign rsp_read_data       = rsp_read_data_ff;
   assign rsp_access_status   = rsp_status_ff;
   assign rsp_me_interrupt    = rsp_irq_ff;
   assign rsp_reset_pulse     = rsp_pulse_ff;
   assign rsp_gpio_enable_out = rsp_gpio_ff;

endmodule
